// ----- design/drh_pkg.sv -----
// drh_pkg: types, codes and constants of the double rolling hash block
// no dependencies; imported by every module of the block
`default_nettype none

package drh_pkg;

    localparam int MAX_LENGTH   = 4096;
    localparam int HASH_WIDTH   = 30;
    localparam int SYMBOL_WIDTH = 16;
    localparam int LEN_WIDTH    = 13;
    localparam int BASE_WIDTH   = 12;
    localparam int CFG_IDX_WIDTH = 2;
    localparam int LANES        = 2;
    localparam int OP_WIDTH     = (HASH_WIDTH > SYMBOL_WIDTH) ? HASH_WIDTH : SYMBOL_WIDTH;

    localparam logic [HASH_WIDTH-1:0] MOD_FLOOR    = HASH_WIDTH'(4096);
    localparam logic [BASE_WIDTH-1:0] BASE_A_RESET = BASE_WIDTH'(307);
    localparam logic [BASE_WIDTH-1:0] BASE_B_RESET = BASE_WIDTH'(509);
    localparam logic [HASH_WIDTH-1:0] MOD_A_RESET  = HASH_WIDTH'(1000000007);
    localparam logic [HASH_WIDTH-1:0] MOD_B_RESET  = HASH_WIDTH'(1000000009);

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        REG_BASE_A,
        REG_BASE_B,
        REG_MOD_A,
        REG_MOD_B
    } cfg_reg_t;

    typedef enum logic [1:0] {
        MODE_CLEAR,
        MODE_APPEND,
        MODE_QUERY
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK,
        ST_BAD_RANGE,
        ST_FULL
    } status_t;

    typedef enum logic [3:0] {
        OP_SYM,
        OP_PRE_APP,
        OP_PW_APP,
        OP_HR1,
        OP_PW1,
        OP_RNG1,
        OP_HR2,
        OP_PW2,
        OP_RNG2,
        OP_JOIN
    } op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_GO,
        S_WAIT,
        S_FIN
    } state_t;

    typedef struct packed {
        mode_t                   mode;
        logic [SYMBOL_WIDTH-1:0] symbol;
        logic [LEN_WIDTH-1:0]    first_left;
        logic [LEN_WIDTH-1:0]    first_right;
        logic [LEN_WIDTH-1:0]    second_left;
        logic [LEN_WIDTH-1:0]    second_right;
    } item_t;

    typedef struct packed {
        status_t               status;
        logic [HASH_WIDTH-1:0] first_hash_a;
        logic [HASH_WIDTH-1:0] first_hash_b;
        logic [HASH_WIDTH-1:0] second_hash_a;
        logic [HASH_WIDTH-1:0] second_hash_b;
        logic [HASH_WIDTH-1:0] joined_hash_a;
        logic [HASH_WIDTH-1:0] joined_hash_b;
        logic                  ranges_equal;
        logic [LEN_WIDTH-1:0]  current_length;
    } result_t;

    typedef struct packed {
        logic                 load;
        logic                 mm_start;
        op_t                  op;
        logic [LEN_WIDTH-1:0] pre_addr;
        logic [LEN_WIDTH-1:0] pw_addr;
        logic                 wr_en;
        logic [LEN_WIDTH-1:0] wr_addr;
        logic                 fin;
        status_t              status;
        logic                 hash_on;
        logic [LEN_WIDTH-1:0] length;
    } dp_cmd_t;

endpackage

`default_nettype wire

// ----- design/drh_modmul.sv -----
// drh_modmul: bit-serial (a * b + c) or (c - a * b) modulo m, one bit of a per cycle
// depends on drh_pkg
`default_nettype none

module drh_modmul (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic                            sub,
    input  logic [drh_pkg::OP_WIDTH-1:0]    a,
    input  logic [drh_pkg::HASH_WIDTH-1:0]  b,
    input  logic [drh_pkg::HASH_WIDTH-1:0]  c,
    input  logic [drh_pkg::HASH_WIDTH-1:0]  m,
    output logic                            done,
    output logic [drh_pkg::HASH_WIDTH-1:0]  result
);
    import drh_pkg::*;

    localparam int CW = $clog2(OP_WIDTH + 1);

    logic                  busy_reg;
    logic                  done_reg;
    logic                  sub_reg;
    logic [CW-1:0]         cnt_reg;
    logic [OP_WIDTH-1:0]   a_reg;
    logic [HASH_WIDTH-1:0] b_reg;
    logic [HASH_WIDTH-1:0] c_reg;
    logic [HASH_WIDTH-1:0] acc_reg;

    logic [HASH_WIDTH+1:0] dbl;
    logic [HASH_WIDTH+1:0] twice_m;
    logic [HASH_WIDTH+1:0] once_m;
    logic [HASH_WIDTH+1:0] step_val;
    logic [HASH_WIDTH:0]   sum;
    logic [HASH_WIDTH:0]   fin_val;

    always_comb
    begin
        twice_m = {1'b0, m, 1'b0};
        once_m  = {2'b00, m};
        dbl     = {1'b0, acc_reg, 1'b0} + (a_reg[OP_WIDTH-1] ? {2'b00, b_reg} : '0);
        if (dbl >= twice_m)
        begin
            step_val = dbl - twice_m;
        end
        else if (dbl >= once_m)
        begin
            step_val = dbl - once_m;
        end
        else
        begin
            step_val = dbl;
        end
        sum = {1'b0, acc_reg} + {1'b0, c_reg};
        if (sub_reg)
        begin
            if (c_reg >= acc_reg)
            begin
                fin_val = {1'b0, c_reg} - {1'b0, acc_reg};
            end
            else
            begin
                fin_val = {1'b0, c_reg} + {1'b0, m} - {1'b0, acc_reg};
            end
        end
        else if (sum >= {1'b0, m})
        begin
            fin_val = sum - {1'b0, m};
        end
        else
        begin
            fin_val = sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(OP_WIDTH);
            end
            else if (busy_reg)
            begin
                if (cnt_reg != '0)
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
                else
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            c_reg   <= c;
            sub_reg <= sub;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg != '0)
            begin
                acc_reg <= step_val[HASH_WIDTH-1:0];
                a_reg   <= {a_reg[OP_WIDTH-2:0], 1'b0};
            end
            else
            begin
                acc_reg <= fin_val[HASH_WIDTH-1:0];
            end
        end
    end

    assign done   = done_reg;
    assign result = acc_reg;

endmodule

`default_nettype wire

// ----- design/drh_datapath.sv -----
// drh_datapath: configuration registers, prefix and power tables, two hash lanes
// depends on drh_pkg and drh_modmul
`default_nettype none

module drh_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  drh_pkg::item_t                      item,
    input  logic                                cfg_write,
    input  logic [drh_pkg::CFG_IDX_WIDTH-1:0]   cfg_index,
    input  logic [drh_pkg::HASH_WIDTH-1:0]      cfg_data,
    input  drh_pkg::dp_cmd_t                    cmd,
    output logic                                mm_done,
    output drh_pkg::result_t                    result
);
    import drh_pkg::*;

    logic [BASE_WIDTH-1:0]   base_reg [LANES];
    logic [HASH_WIDTH-1:0]   mod_reg  [LANES];
    logic [SYMBOL_WIDTH-1:0] symbol_reg;
    result_t                 result_reg;

    logic [HASH_WIDTH-1:0] first_w  [LANES];
    logic [HASH_WIDTH-1:0] second_w [LANES];
    logic [HASH_WIDTH-1:0] joined_w [LANES];
    logic                  done_w   [LANES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg[0] <= BASE_A_RESET;
            base_reg[1] <= BASE_B_RESET;
            mod_reg[0]  <= MOD_A_RESET;
            mod_reg[1]  <= MOD_B_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_BASE_A: base_reg[0] <= cfg_data[BASE_WIDTH-1:0];
                REG_BASE_B: base_reg[1] <= cfg_data[BASE_WIDTH-1:0];
                REG_MOD_A:  mod_reg[0]  <= cfg_data;
                REG_MOD_B:  mod_reg[1]  <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            symbol_reg <= item.symbol;
        end
    end

    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        logic [HASH_WIDTH-1:0] pre_mem [0:MAX_LENGTH];
        logic [HASH_WIDTH-1:0] pw_mem  [0:MAX_LENGTH];
        logic [HASH_WIDTH-1:0] rd_pre_reg;
        logic [HASH_WIDTH-1:0] rd_pw_reg;
        logic                  pre_zero_reg;
        logic                  pw_zero_reg;
        logic [HASH_WIDTH-1:0] rd_pre;
        logic [HASH_WIDTH-1:0] rd_pw;
        logic [HASH_WIDTH-1:0] eff_mod;
        logic [HASH_WIDTH-1:0] sym_red_reg;
        logic [HASH_WIDTH-1:0] new_pre_reg;
        logic [HASH_WIDTH-1:0] new_pw_reg;
        logic [HASH_WIDTH-1:0] hr_reg;
        logic [HASH_WIDTH-1:0] p_reg;
        logic [HASH_WIDTH-1:0] first_reg;
        logic [HASH_WIDTH-1:0] second_reg;
        logic [HASH_WIDTH-1:0] joined_reg;
        logic [OP_WIDTH-1:0]   mm_a;
        logic [HASH_WIDTH-1:0] mm_b;
        logic [HASH_WIDTH-1:0] mm_c;
        logic                  mm_sub;
        logic                  mm_fin;
        logic [HASH_WIDTH-1:0] mm_res;

        always_ff @(posedge clk)
        begin
            if (cmd.wr_en)
            begin
                pre_mem[cmd.wr_addr] <= new_pre_reg;
                pw_mem[cmd.wr_addr]  <= new_pw_reg;
            end
            rd_pre_reg   <= pre_mem[cmd.pre_addr];
            rd_pw_reg    <= pw_mem[cmd.pw_addr];
            pre_zero_reg <= (cmd.pre_addr == '0);
            pw_zero_reg  <= (cmd.pw_addr == '0);
        end

        // entry 0 of each table is fixed
        assign rd_pre  = pre_zero_reg ? '0 : rd_pre_reg;
        assign rd_pw   = pw_zero_reg ? HASH_WIDTH'(1) : rd_pw_reg;
        assign eff_mod = (mod_reg[g] < MOD_FLOOR) ? MOD_FLOOR : mod_reg[g];

        always_comb
        begin
            mm_a   = '0;
            mm_b   = '0;
            mm_c   = '0;
            mm_sub = 1'b0;
            case (cmd.op) inside
                OP_SYM:
                begin
                    mm_a = OP_WIDTH'(symbol_reg);
                    mm_b = HASH_WIDTH'(1);
                end
                OP_PRE_APP:
                begin
                    mm_a = OP_WIDTH'(rd_pre);
                    mm_b = HASH_WIDTH'(base_reg[g]);
                    mm_c = sym_red_reg;
                end
                OP_PW_APP:
                begin
                    mm_a = OP_WIDTH'(rd_pw);
                    mm_b = HASH_WIDTH'(base_reg[g]);
                end
                OP_HR1, OP_HR2:
                begin
                    mm_a = OP_WIDTH'(rd_pre);
                    mm_b = HASH_WIDTH'(1);
                end
                OP_PW1, OP_PW2:
                begin
                    mm_a = OP_WIDTH'(rd_pw);
                    mm_b = HASH_WIDTH'(1);
                end
                OP_RNG1, OP_RNG2:
                begin
                    mm_a   = OP_WIDTH'(rd_pre);
                    mm_b   = p_reg;
                    mm_c   = hr_reg;
                    mm_sub = 1'b1;
                end
                OP_JOIN:
                begin
                    mm_a = OP_WIDTH'(first_reg);
                    mm_b = p_reg;
                    mm_c = second_reg;
                end
                default: ;
            endcase
        end

        drh_modmul u_modmul (
            .clk    (clk),
            .rst_n  (rst_n),
            .start  (cmd.mm_start),
            .sub    (mm_sub),
            .a      (mm_a),
            .b      (mm_b),
            .c      (mm_c),
            .m      (eff_mod),
            .done   (mm_fin),
            .result (mm_res)
        );

        always_ff @(posedge clk)
        begin
            if (mm_fin)
            begin
                case (cmd.op) inside
                    OP_SYM:           sym_red_reg <= mm_res;
                    OP_PRE_APP:       new_pre_reg <= mm_res;
                    OP_PW_APP:        new_pw_reg  <= mm_res;
                    OP_HR1, OP_HR2:   hr_reg      <= mm_res;
                    OP_PW1, OP_PW2:   p_reg       <= mm_res;
                    OP_RNG1:          first_reg   <= mm_res;
                    OP_RNG2:          second_reg  <= mm_res;
                    OP_JOIN:          joined_reg  <= mm_res;
                    default: ;
                endcase
            end
        end

        assign first_w[g]  = first_reg;
        assign second_w[g] = second_reg;
        assign joined_w[g] = joined_reg;
        assign done_w[g]   = mm_fin;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fin)
        begin
            result_reg.status         <= cmd.status;
            result_reg.current_length <= cmd.length;
            if (cmd.hash_on)
            begin
                result_reg.first_hash_a  <= first_w[0];
                result_reg.first_hash_b  <= first_w[1];
                result_reg.second_hash_a <= second_w[0];
                result_reg.second_hash_b <= second_w[1];
                result_reg.joined_hash_a <= joined_w[0];
                result_reg.joined_hash_b <= joined_w[1];
                result_reg.ranges_equal  <= (first_w[0] == second_w[0])
                                            && (first_w[1] == second_w[1]);
            end
            else
            begin
                result_reg.first_hash_a  <= '0;
                result_reg.first_hash_b  <= '0;
                result_reg.second_hash_a <= '0;
                result_reg.second_hash_b <= '0;
                result_reg.joined_hash_a <= '0;
                result_reg.joined_hash_b <= '0;
                result_reg.ranges_equal  <= 1'b0;
            end
        end
    end

    assign mm_done = done_w[0];
    assign result  = result_reg;

endmodule

`default_nettype wire

// ----- design/drh_ctrl.sv -----
// drh_ctrl: item handshake, string length, operation sequencer and result beat
// depends on drh_pkg
`default_nettype none

module drh_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  drh_pkg::item_t    item,
    output logic              result_valid,
    input  logic              result_stall,
    input  logic              mm_done,
    output drh_pkg::dp_cmd_t  cmd
);
    import drh_pkg::*;

    state_t               state_reg, state_next;
    op_t                  op_reg, op_next;
    logic                 result_valid_reg, result_valid_next;
    logic [LEN_WIDTH-1:0] len_reg, len_next;
    status_t              status_reg;
    logic                 hash_on_reg;
    logic                 grow_reg;
    logic                 clear_reg;
    logic [LEN_WIDTH-1:0] fl_reg, fr_reg, sl_reg, sr_reg;

    logic                 accept;
    logic                 ok1, ok2, full;
    status_t              status_in;
    logic                 grow_in;
    logic                 query_in;
    logic [LEN_WIDTH-1:0] span1, span2;

    function automatic logic range_ok(input logic [LEN_WIDTH-1:0] l,
                                      input logic [LEN_WIDTH-1:0] r,
                                      input logic [LEN_WIDTH-1:0] n);
        return (l != '0) && (l <= r) && (r <= n);
    endfunction

    assign accept = item_valid && (state_reg == S_IDLE);
    assign ok1    = range_ok(item.first_left, item.first_right, len_reg);
    assign ok2    = range_ok(item.second_left, item.second_right, len_reg);
    assign full   = (len_reg >= LEN_WIDTH'(MAX_LENGTH));
    assign span1  = fr_reg - fl_reg + 1'b1;
    assign span2  = sr_reg - sl_reg + 1'b1;

    always_comb
    begin
        status_in = ST_OK;
        grow_in   = 1'b0;
        query_in  = 1'b0;
        case (item.mode)
            MODE_APPEND:
            begin
                if (full)
                begin
                    status_in = ST_FULL;
                end
                else
                begin
                    grow_in = 1'b1;
                end
            end
            MODE_QUERY:
            begin
                if (ok1 && ok2)
                begin
                    query_in = 1'b1;
                end
                else
                begin
                    status_in = ST_BAD_RANGE;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            op_reg           <= OP_SYM;
            result_valid_reg <= 1'b0;
            len_reg          <= '0;
            status_reg       <= ST_OK;
            hash_on_reg      <= 1'b0;
            grow_reg         <= 1'b0;
            clear_reg        <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            op_reg           <= op_next;
            result_valid_reg <= result_valid_next;
            len_reg          <= len_next;
            if (accept)
            begin
                status_reg  <= status_in;
                hash_on_reg <= query_in;
                grow_reg    <= grow_in;
                clear_reg   <= (item.mode == MODE_CLEAR);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            fl_reg <= item.first_left;
            fr_reg <= item.first_right;
            sl_reg <= item.second_left;
            sr_reg <= item.second_right;
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        op_next           = op_reg;
        len_next          = len_reg;
        result_valid_next = result_valid_reg && result_stall;
        cmd               = '0;
        cmd.op            = op_reg;
        cmd.status        = status_reg;
        cmd.hash_on       = hash_on_reg;
        cmd.wr_addr       = len_reg + 1'b1;
        cmd.length        = len_reg;

        case (op_reg)
            OP_HR1, OP_PW1:
            begin
                cmd.pre_addr = fr_reg;
                cmd.pw_addr  = span1;
            end
            OP_RNG1:
            begin
                cmd.pre_addr = fl_reg - 1'b1;
                cmd.pw_addr  = span1;
            end
            OP_HR2, OP_PW2, OP_JOIN:
            begin
                cmd.pre_addr = sr_reg;
                cmd.pw_addr  = span2;
            end
            OP_RNG2:
            begin
                cmd.pre_addr = sl_reg - 1'b1;
                cmd.pw_addr  = span2;
            end
            default:
            begin
                cmd.pre_addr = len_reg;
                cmd.pw_addr  = len_reg;
            end
        endcase

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.load = 1'b1;
                    if (grow_in)
                    begin
                        op_next    = OP_SYM;
                        state_next = S_LOAD;
                    end
                    else if (query_in)
                    begin
                        op_next    = OP_HR1;
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        state_next = S_FIN;
                    end
                end
            end
            S_LOAD:
            begin
                state_next = S_GO;
            end
            S_GO:
            begin
                cmd.mm_start = 1'b1;
                state_next   = S_WAIT;
            end
            S_WAIT:
            begin
                if (mm_done)
                begin
                    state_next = S_LOAD;
                    unique case (op_reg)
                        OP_SYM:     op_next = OP_PRE_APP;
                        OP_PRE_APP: op_next = OP_PW_APP;
                        OP_HR1:     op_next = OP_PW1;
                        OP_PW1:     op_next = OP_RNG1;
                        OP_RNG1:    op_next = OP_HR2;
                        OP_HR2:     op_next = OP_PW2;
                        OP_PW2:     op_next = OP_RNG2;
                        OP_RNG2:    op_next = OP_JOIN;
                        default:    state_next = S_FIN;
                    endcase
                end
            end
            S_FIN:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    if (clear_reg)
                    begin
                        len_next = '0;
                    end
                    else if (grow_reg)
                    begin
                        len_next = len_reg + 1'b1;
                    end
                    cmd.fin           = 1'b1;
                    cmd.wr_en         = grow_reg;
                    cmd.length        = len_next;
                    result_valid_next = 1'b1;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign item_stall   = (state_reg != S_IDLE);
    assign result_valid = result_valid_reg;

endmodule

`default_nettype wire

// ----- design/double_rolling_hash_range_query.sv -----
// double_rolling_hash_range_query: top level, sequencer plus two-lane hash datapath
// depends on drh_pkg, drh_ctrl, drh_datapath, drh_modmul
//
//  channel   signals                          direction
//  item      item_valid, item_stall, item     in  (stall driven here)
//  result    result_valid, result_stall, result  out (stall from sink)
//  config    cfg_valid, cfg_ready, cfg_index, cfg_data  in (ready always high)
//
// each modular product runs on one shared bit-serial unit per lane
// append runs 3 products between acceptance and result; a query runs 7
// clear, full-store append, bad range and spare mode: no product; the result is registered from S_FIN
// a new item is taken while the last result beat waits; reset clears length and handshakes
`default_nettype none

module double_rolling_hash_range_query (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               item_valid,
    output logic                               item_stall,
    input  drh_pkg::item_t                     item,
    output logic                               result_valid,
    input  logic                               result_stall,
    output drh_pkg::result_t                   result,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [drh_pkg::CFG_IDX_WIDTH-1:0]  cfg_index,
    input  logic [drh_pkg::HASH_WIDTH-1:0]     cfg_data
);
    import drh_pkg::*;

    dp_cmd_t cmd;
    logic    mm_done;

    assign cfg_ready = 1'b1;

    drh_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .mm_done      (mm_done),
        .cmd          (cmd)
    );

    drh_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .mm_done   (mm_done),
        .result    (result)
    );

`ifndef SYNTHESIS
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.current_length <= LEN_WIDTH'(MAX_LENGTH)))
        else $error("reported length beyond store size");

    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.status != ST_OK) |->
            (result.first_hash_a == '0 && result.joined_hash_b == '0
             && !result.ranges_equal))
        else $error("hash fields set on refused item");

    a_equal_match: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.ranges_equal) |->
            (result.first_hash_a == result.second_hash_a
             && result.first_hash_b == result.second_hash_b))
        else $error("equality flag without matching hashes");

    a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall && item.mode == MODE_QUERY) |=> item_stall)
        else $error("item taken during a query");
`endif

endmodule

`default_nettype wire

// ----- test/drh_checker.sv -----
// drh_checker: watches the item, result and config channels of the double rolling hash block
// keeps its own hash tables, predicts every result beat and compares field by field
// depends on drh_pkg
`timescale 1ns / 100ps

module drh_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               item_valid,
    input  logic                               item_stall,
    input  drh_pkg::item_t                     item,
    input  logic                               result_valid,
    input  logic                               result_stall,
    input  drh_pkg::result_t                   result,
    input  logic                               cfg_valid,
    input  logic                               cfg_ready,
    input  logic [drh_pkg::CFG_IDX_WIDTH-1:0]  cfg_index,
    input  logic [drh_pkg::HASH_WIDTH-1:0]     cfg_data,
    output int                                 mismatches,
    output int                                 pending
);
    import drh_pkg::*;

    localparam longint unsigned HASH_TOP = (64'd1 << HASH_WIDTH) - 1;

    logic [HASH_WIDTH-1:0] prefix_tab [2][0:MAX_LENGTH];
    logic [HASH_WIDTH-1:0] power_tab  [2][0:MAX_LENGTH];
    longint unsigned       hash_base  [2];
    longint unsigned       hash_mod   [2];
    int                    str_len;
    result_t               expected_q [$];

    function automatic longint unsigned clamp_mod(input longint unsigned m);
        if (m < 4096)
            return 4096;
        if (m > HASH_TOP)
            return HASH_TOP;
        return m;
    endfunction

    function automatic longint unsigned span_hash(input int lane, input int l, input int r,
                                                 input longint unsigned m);
        longint unsigned hr, hl, p;
        hr = prefix_tab[lane][r] % m;
        hl = prefix_tab[lane][l-1] % m;
        p  = power_tab[lane][r-l+1] % m;
        return (hr + m - (hl * p) % m) % m;
    endfunction

    function automatic bit span_ok(input int l, input int r);
        return l >= 1 && l <= r && r <= str_len;
    endfunction

    // advances the shadow string and returns the beat the block should give
    function automatic result_t step_string(input item_t it);
        result_t         res;
        longint unsigned m [2];
        longint unsigned fh [2], sh [2], q;
        int              l1, r1, l2, r2;
        res = '0;
        m[0] = clamp_mod(hash_mod[0]);
        m[1] = clamp_mod(hash_mod[1]);
        l1 = it.first_left;
        r1 = it.first_right;
        l2 = it.second_left;
        r2 = it.second_right;
        case (it.mode)
            MODE_CLEAR: str_len = 0;
            MODE_APPEND:
                if (str_len >= MAX_LENGTH)
                    res.status = ST_FULL;
                else
                begin
                    for (int k = 0; k < 2; k++)
                    begin
                        prefix_tab[k][str_len+1] = HASH_WIDTH'(
                            ((prefix_tab[k][str_len] % m[k]) * hash_base[k] + it.symbol) % m[k]);
                        power_tab[k][str_len+1] = HASH_WIDTH'(
                            ((power_tab[k][str_len] % m[k]) * hash_base[k]) % m[k]);
                    end
                    str_len++;
                end
            MODE_QUERY:
                if (!span_ok(l1, r1) || !span_ok(l2, r2))
                    res.status = ST_BAD_RANGE;
                else
                begin
                    for (int k = 0; k < 2; k++)
                    begin
                        fh[k] = span_hash(k, l1, r1, m[k]);
                        sh[k] = span_hash(k, l2, r2, m[k]);
                    end
                    res.first_hash_a  = HASH_WIDTH'(fh[0]);
                    res.first_hash_b  = HASH_WIDTH'(fh[1]);
                    res.second_hash_a = HASH_WIDTH'(sh[0]);
                    res.second_hash_b = HASH_WIDTH'(sh[1]);
                    q = power_tab[0][r2-l2+1] % m[0];
                    res.joined_hash_a = HASH_WIDTH'((fh[0] * q + sh[0]) % m[0]);
                    q = power_tab[1][r2-l2+1] % m[1];
                    res.joined_hash_b = HASH_WIDTH'((fh[1] * q + sh[1]) % m[1]);
                    res.ranges_equal  = (fh[0] == sh[0]) && (fh[1] == sh[1]);
                end
            default: ;
        endcase
        res.current_length = LEN_WIDTH'(str_len);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t exp_beat;
        if (!rst_n)
        begin
            hash_base[0] = BASE_A_RESET;
            hash_base[1] = BASE_B_RESET;
            hash_mod[0]  = MOD_A_RESET;
            hash_mod[1]  = MOD_B_RESET;
            str_len      = 0;
            for (int k = 0; k < 2; k++)
                for (int i = 0; i <= MAX_LENGTH; i++)
                begin
                    prefix_tab[k][i] = '0;
                    power_tab[k][i]  = (i == 0) ? 1 : 0;
                end
            expected_q.delete();
            mismatches <= 0;
            pending    <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                case (cfg_reg_t'(cfg_index))
                    REG_BASE_A: hash_base[0] = cfg_data[BASE_WIDTH-1:0];
                    REG_BASE_B: hash_base[1] = cfg_data[BASE_WIDTH-1:0];
                    REG_MOD_A:  hash_mod[0]  = cfg_data;
                    REG_MOD_B:  hash_mod[1]  = cfg_data;
                    default: ;
                endcase
            if (item_valid && !item_stall)
                expected_q.push_back(step_string(item));
            if (result_valid && !result_stall)
            begin
                if (expected_q.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("unexpected result beat %p", result);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    exp_beat = expected_q.pop_front();
                    if (result.status !== exp_beat.status
                        || result.first_hash_a !== exp_beat.first_hash_a
                        || result.first_hash_b !== exp_beat.first_hash_b
                        || result.second_hash_a !== exp_beat.second_hash_a
                        || result.second_hash_b !== exp_beat.second_hash_b
                        || result.joined_hash_a !== exp_beat.joined_hash_a
                        || result.joined_hash_b !== exp_beat.joined_hash_b
                        || result.ranges_equal !== exp_beat.ranges_equal
                        || result.current_length !== exp_beat.current_length)
                    begin
                        if (mismatches < 10)
                            $display("result mismatch: expected %p got %p", exp_beat, result);
                        mismatches <= mismatches + 1;
                    end
                end
            end
            pending <= expected_q.size();
        end
    end

endmodule

// ----- test/tb_double_rolling_hash_range_query.sv -----
// tb_double_rolling_hash_range_query: stimulus and verdict for the double rolling hash block
// directed items, register phases, random bursts, a full store fill; checking in drh_checker
// depends on drh_pkg, double_rolling_hash_range_query, drh_checker
`timescale 1ns / 100ps

module tb_double_rolling_hash_range_query;
    import drh_pkg::*;

    localparam int CYCLE_LIMIT = 6000000;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      item_valid = 1'b0;
    logic                      item_stall;
    item_t                     item = '0;
    logic                      result_valid;
    logic                      result_stall;
    result_t                   result;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_IDX_WIDTH-1:0]  cfg_index = '0;
    logic [HASH_WIDTH-1:0]     cfg_data = '0;
    int                        mismatches;
    int                        pending;

    logic                      pattern_stall = 1'b0;
    logic                      hold_stall = 1'b0;
    bit                        hold_go = 1'b0;
    int                        cycles = 0;
    int                        burst_left = 0;
    int                        shadow_len = 0;

    assign result_stall = pattern_stall | hold_stall;

    double_rolling_hash_range_query u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    drh_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mismatches   (mismatches),
        .pending      (pending)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[double_rolling_hash_range_query] ERROR");
            $finish;
        end
    end

    // receiver stall pattern: steps through four stall densities in turn, the first with no stalls
    always @(posedge clk)
    begin
        int stall_kind;
        stall_kind = (cycles / 350) % 4;
        case (stall_kind)
            0: pattern_stall <= 1'b0;
            1: pattern_stall <= ($urandom_range(0, 7) == 0);
            2: pattern_stall <= ($urandom_range(0, 1) == 0);
            default: pattern_stall <= ($urandom_range(0, 30) == 0);
        endcase
    end

    // one long receiver hold-off while items keep coming
    initial
    begin
        wait (hold_go);
        @(posedge clk);
        hold_stall <= 1'b1;
        repeat (3000) @(posedge clk);
        hold_stall <= 1'b0;
    end

    task automatic put_item(input item_t it);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 12);
            if (gap > 0)
            begin
                item_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        item       <= it;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (item_stall);
        burst_left--;
        case (it.mode)
            MODE_CLEAR:  shadow_len = 0;
            MODE_APPEND: if (shadow_len < MAX_LENGTH) shadow_len++;
            default: ;
        endcase
    endtask

    task automatic put_op(input mode_t md, input int sym, input int l1, input int r1,
                          input int l2, input int r2);
        item_t it;
        it.mode         = md;
        it.symbol       = SYMBOL_WIDTH'(sym);
        it.first_left   = LEN_WIDTH'(l1);
        it.first_right  = LEN_WIDTH'(r1);
        it.second_left  = LEN_WIDTH'(l2);
        it.second_right = LEN_WIDTH'(r2);
        put_item(it);
    endtask

    task automatic drain;
        item_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    // drives one register beat; the caller drops valid after the last one
    task automatic write_reg(input cfg_reg_t idx, input int unsigned value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= HASH_WIDTH'(value);
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    task automatic set_hashes(input int unsigned ba, input int unsigned bb,
                              input int unsigned ma, input int unsigned mb);
        drain();
        write_reg(REG_BASE_A, ba);
        write_reg(REG_BASE_B, bb);
        write_reg(REG_MOD_A, ma);
        write_reg(REG_MOD_B, mb);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic put_random;
        item_t it;
        int    pick, len, l1, l2;
        pick = $urandom_range(0, 99);
        it = item_t'({$urandom, $urandom, $urandom});
        if (pick < 4)
            it.mode = MODE_CLEAR;
        else if (pick < 8)
            it.mode = mode_t'(2'd3);
        else if (pick < 45)
        begin
            it.mode = MODE_APPEND;
            if ($urandom_range(0, 1) == 0)
                it.symbol = SYMBOL_WIDTH'($urandom_range(0, 2));
        end
        else if (pick < 55 || shadow_len == 0)
            it.mode = MODE_QUERY;
        else
        begin
            it.mode = MODE_QUERY;
            len = $urandom_range(1, (shadow_len < 8) ? shadow_len : 8);
            l1 = $urandom_range(1, shadow_len - len + 1);
            l2 = ($urandom_range(0, 3) == 0) ? l1 : $urandom_range(1, shadow_len - len + 1);
            it.first_left   = LEN_WIDTH'(l1);
            it.first_right  = LEN_WIDTH'(l1 + len - 1);
            it.second_left  = LEN_WIDTH'(l2);
            it.second_right = LEN_WIDTH'(($urandom_range(0, 4) == 0)
                ? $urandom_range(l2, shadow_len) : l2 + len - 1);
        end
        put_item(it);
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        put_op(MODE_QUERY, 0, 1, 1, 1, 1);
        put_op(MODE_CLEAR, 0, 0, 0, 0, 0);
        put_op(MODE_APPEND, 0, 0, 0, 0, 0);
        put_op(MODE_APPEND, 65535, 0, 0, 0, 0);
        put_op(MODE_APPEND, 1, 0, 0, 0, 0);
        put_op(MODE_APPEND, 2, 0, 0, 0, 0);
        put_op(MODE_APPEND, 1, 0, 0, 0, 0);
        put_op(MODE_APPEND, 2, 0, 0, 0, 0);
        put_op(MODE_QUERY, 0, 3, 4, 5, 6);
        put_op(MODE_QUERY, 0, 1, 6, 1, 6);
        put_op(MODE_QUERY, 0, 6, 6, 1, 1);
        put_op(MODE_QUERY, 0, 1, 1, 2, 2);
        put_op(MODE_QUERY, 0, 4, 3, 1, 1);
        put_op(MODE_QUERY, 0, 1, 7, 1, 1);
        put_op(MODE_QUERY, 0, 0, 2, 1, 1);
        put_op(MODE_QUERY, 0, 1, 1, 2, 1);
        put_op(MODE_QUERY, 8191, 8191, 8191, 8191, 8191);
        put_op(mode_t'(2'd3), 65535, 8191, 8191, 8191, 8191);
        put_op(MODE_APPEND, 32768, 0, 0, 0, 0);
        put_op(MODE_QUERY, 0, 1, 7, 7, 7);
        put_op(MODE_CLEAR, 0, 0, 0, 0, 0);
        put_op(MODE_QUERY, 0, 1, 1, 1, 1);

        hold_go = 1'b1;
        for (int i = 0; i < 200; i++)
            put_random();

        set_hashes(2, 4095, 4096, 1073741823);
        for (int i = 0; i < 200; i++)
            put_random();
        set_hashes(4095, 2, 1073741823, 4096);
        for (int i = 0; i < 200; i++)
            put_random();
        set_hashes(0, 1, 5, 0);
        for (int i = 0; i < 150; i++)
            put_random();
        set_hashes(31, 37, 1000003, 998244353);
        for (int i = 0; i < 200; i++)
            put_random();

        // fill the store to the top, then refused appends and wide queries
        put_op(MODE_CLEAR, 0, 0, 0, 0, 0);
        while (shadow_len < MAX_LENGTH)
            put_op(MODE_APPEND, $urandom_range(0, 65535), 0, 0, 0, 0);
        put_op(MODE_APPEND, 7, 0, 0, 0, 0);
        put_op(MODE_APPEND, 65535, 0, 0, 0, 0);
        put_op(MODE_QUERY, 0, 1, MAX_LENGTH, 1, MAX_LENGTH);
        put_op(MODE_QUERY, 0, 1, MAX_LENGTH - 1, MAX_LENGTH, MAX_LENGTH);
        put_op(MODE_QUERY, 0, 1, MAX_LENGTH + 1, 1, 1);

        set_hashes(307, 509, 1000000007, 1000000009);
        put_op(MODE_QUERY, 0, 1, 100, 50, 4000);
        for (int i = 0; i < 250; i++)
            put_random();

        drain();
        if (mismatches == 0 && pending == 0)
            $display("[double_rolling_hash_range_query] OK");
        else
            $display("[double_rolling_hash_range_query] ERROR");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/drh_pkg.sv
design/drh_modmul.sv
design/drh_datapath.sv
design/drh_ctrl.sv
design/double_rolling_hash_range_query.sv
test/drh_checker.sv
test/tb_double_rolling_hash_range_query.sv
